// ----- hdl/olst_pkg.sv -----
// shared types and constants for the ordered list store
package olst_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VAL_W      = 32;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 5;
    localparam int STS_W      = 3;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        REQ_APPEND     = 2'd0,
        REQ_FRONT      = 2'd1,
        REQ_REMOVE_POS = 2'd2,
        REQ_REMOVE_VAL = 2'd3
    } t_req_kind;

    typedef enum logic [STS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_RANGE   = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    typedef struct packed {
        logic      cap;
        logic      commit;
        t_req_kind kind;
    } t_cell_ctl;

endpackage

// ----- hdl/olst_req_if.sv -----
// request and response channel interfaces
interface olst_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic signed [olst_pkg::VAL_W-1:0] item_value;
    logic [olst_pkg::POS_W-1:0]        item_position;

    modport source (output valid, req_type, item_value, item_position, input ready);
    modport sink   (input valid, req_type, item_value, item_position, output ready);
endinterface

interface olst_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [olst_pkg::STS_W-1:0] status;
    logic [olst_pkg::LEN_W-1:0] list_length;

    modport source (output valid, status, list_length, input ready);
    modport sink   (input valid, status, list_length, output ready);
endinterface

// ----- hdl/ordered_list_store.sv -----
// top level of the ordered list store
//
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid / ready | req_type, item_value, item_position
//  o_rsp    | out | valid / ready | status, list_length
//
// each request has a transfer cycle, where every cell compares its value with
// item_value, then an execute state that resolves the first match along the
// cell chain and shifts the cells, or writes the tail cell, all at once.
// reset empties the list at once; stored values are not cleared.
// a request is taken while an earlier response still waits; its execute cycle
// then holds until the response register is free.
module ordered_list_store (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olst_req_if.sink   i_req,
    olst_rsp_if.source o_rsp
);
    localparam int D = olst_pkg::LIST_DEPTH;

    olst_pkg::t_fsm      r_state;
    olst_pkg::t_fsm      n_state;
    olst_pkg::t_req_kind r_kind;
    logic signed [olst_pkg::VAL_W-1:0] r_val;
    logic [olst_pkg::POS_W-1:0]        r_pos;
    logic [olst_pkg::CNT_W-1:0]        r_count;
    logic [olst_pkg::CNT_W-1:0]        n_count;
    logic                              r_out_valid;
    olst_pkg::t_status                 r_status;
    logic [olst_pkg::LEN_W-1:0]        r_len;

    logic              w_take;
    logic              w_go;
    logic              w_full;
    logic              w_empty;
    olst_pkg::t_status w_status;
    olst_pkg::t_cell_ctl w_ctl;

    logic signed [olst_pkg::VAL_W-1:0] w_val [D];
    logic                              w_seen [D+1];

    assign w_take  = i_req.valid && i_req.ready;
    assign w_full  = r_count >= olst_pkg::CNT_W'(D);
    assign w_empty = r_count == '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            olst_pkg::FSM_IDLE: begin
                if (w_take) n_state = olst_pkg::FSM_EXEC;
            end
            olst_pkg::FSM_EXEC: begin
                if (w_go) n_state = olst_pkg::FSM_IDLE;
            end
            default: begin
                n_state = olst_pkg::FSM_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_go        = 1'b0;
        case (r_state)
            olst_pkg::FSM_IDLE: begin
                i_req.ready = 1'b1;
            end
            olst_pkg::FSM_EXEC: begin
                w_go = !r_out_valid || o_rsp.ready;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_status = olst_pkg::ST_DONE;
        case (r_kind)
            olst_pkg::REQ_APPEND, olst_pkg::REQ_FRONT: begin
                if (w_full) w_status = olst_pkg::ST_FULL;
            end
            olst_pkg::REQ_REMOVE_POS: begin
                if (w_empty) begin
                    w_status = olst_pkg::ST_EMPTY;
                end else if (olst_pkg::CMP_W'(r_pos) >= olst_pkg::CMP_W'(r_count)) begin
                    w_status = olst_pkg::ST_RANGE;
                end
            end
            olst_pkg::REQ_REMOVE_VAL: begin
                if (w_empty) begin
                    w_status = olst_pkg::ST_EMPTY;
                end else if (!w_seen[D]) begin
                    w_status = olst_pkg::ST_MISSING;
                end
            end
            default: begin
                w_status = olst_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_go && w_status == olst_pkg::ST_DONE) begin
            if (r_kind == olst_pkg::REQ_APPEND || r_kind == olst_pkg::REQ_FRONT) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    assign w_ctl.cap    = w_take;
    assign w_ctl.commit = w_go && (w_status == olst_pkg::ST_DONE);
    assign w_ctl.kind   = r_kind;
    assign w_seen[0]    = 1'b0;

    for (genvar i = 0; i < D; i++) begin : g_cell
        olst_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_live       (olst_pkg::CNT_W'(i) < r_count),
            .i_at_or_past (olst_pkg::CMP_W'(i) >= olst_pkg::CMP_W'(r_pos)),
            .i_is_tail    (olst_pkg::CNT_W'(i) == r_count),
            .i_seen       (w_seen[i]),
            .i_key_in     (i_req.item_value),
            .i_key        (r_val),
            .i_left       ((i == 0) ? r_val : w_val[(i == 0) ? 0 : i-1]),
            .i_right      (w_val[(i == D-1) ? i : i+1]),
            .o_value      (w_val[i]),
            .o_seen       (w_seen[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olst_pkg::FSM_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= olst_pkg::t_req_kind'(i_req.req_type);
            r_val  <= i_req.item_value;
            r_pos  <= i_req.item_position;
        end
        if (w_go) begin
            r_status <= w_status;
            r_len    <= olst_pkg::LEN_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.list_length = r_len;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olst_pkg::CNT_W'(D))
        else $error("entry count beyond list depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == olst_pkg::FSM_IDLE |=> $stable(r_count))
        else $error("entry count moved without a request");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> o_rsp.valid && r_state == olst_pkg::FSM_IDLE)
        else $error("executed request left no response");

    a_no_take_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == olst_pkg::FSM_EXEC |-> !w_take)
        else $error("transfer taken during execute");
`endif
endmodule

// ----- hdl/olst_cell.sv -----
// one list slot: holds a value, compares it and shifts with its neighbors
module olst_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  olst_pkg::t_cell_ctl               i_ctl,
    input  logic                              i_live,
    input  logic                              i_at_or_past,
    input  logic                              i_is_tail,
    input  logic                              i_seen,
    input  logic signed [olst_pkg::VAL_W-1:0] i_key_in,
    input  logic signed [olst_pkg::VAL_W-1:0] i_key,
    input  logic signed [olst_pkg::VAL_W-1:0] i_left,
    input  logic signed [olst_pkg::VAL_W-1:0] i_right,
    output logic signed [olst_pkg::VAL_W-1:0] o_value,
    output logic                              o_seen
);
    logic signed [olst_pkg::VAL_W-1:0] r_value;
    logic signed [olst_pkg::VAL_W-1:0] n_value;
    logic                              r_match;
    logic                              w_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cap) begin
            r_match <= i_live && (r_value == i_key_in);
        end
    end

    // removal window: from the target slot, or the first matching slot, to the back
    always_comb begin
        if (i_ctl.kind == olst_pkg::REQ_REMOVE_POS) begin
            w_region = i_at_or_past;
        end else begin
            w_region = i_seen | r_match;
        end
    end

    always_comb begin
        n_value = r_value;
        if (i_ctl.commit) begin
            case (i_ctl.kind)
                olst_pkg::REQ_APPEND: begin
                    if (i_is_tail) n_value = i_key;
                end
                olst_pkg::REQ_FRONT: begin
                    n_value = i_left;
                end
                olst_pkg::REQ_REMOVE_POS, olst_pkg::REQ_REMOVE_VAL: begin
                    if (w_region) n_value = i_right;
                end
                default: begin
                    n_value = r_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_seen  = i_seen | r_match;
endmodule
